// File: rtl/crdq_pkg.sv
// crdq_pkg: request codes and shared types for the character ring deque.
// No dependencies; used by char_ring_deque_with_unget_core.
package crdq_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_CLEAR  = 3'd0;
  localparam req_t REQ_APPEND = 3'd1;
  localparam req_t REQ_DELETE = 3'd2;
  localparam req_t REQ_TAKE   = 3'd3;
  localparam req_t REQ_UNGET  = 3'd4;

  // status of one item waiting in the output stage
  typedef struct packed {
    logic take_ok;
    logic ok;
    logic is_empty;
    logic is_full;
  } stage_t;

endpackage

// File: rtl/crdq_ram.sv
// crdq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module crdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/char_ring_deque_with_unget_core.sv
// char_ring_deque_with_unget_core: byte ring buffer with append, delete, take and unget.
// Depends on crdq_pkg and crdq_ram.
//
// A byte ring of DEPTH slots holding at most DEPTH-1 bytes. Each request item
// yields one result item in the cycle after acceptance; one request can be
// taken every cycle while out_ready keeps the output stage free (a take reads the
// slot in the accepting cycle and the RAM returns it the cycle after). The
// pointers live in flip-flops, the bytes in the RAM. Append on a full buffer,
// unget on a full buffer, delete or take on an empty buffer and unused request
// codes are refused (ok low, nothing changes). Clear resets both pointers and
// leaves the slot contents alone. Every result carries the empty and full
// flags as they stand after its request. No clearing pass is needed after reset.
module char_ring_deque_with_unget_core #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_ok,
  output logic       out_is_empty,
  output logic       out_is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? LAST : p - 1'b1;
  endfunction

  // pointers: wr names the newest byte, rd the free slot before the oldest
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // output stage
  logic            stg_valid_r, stg_valid_nxt;
  crdq_pkg::stage_t stg_r, stg_nxt;

  logic       accept;
  logic       empty_now, full_now;
  logic       ok;
  logic       take_ok;
  logic       ram_we;
  logic [AW-1:0] ram_waddr;
  logic       ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;

  // hold off while in reset so nothing slips in unnoticed
  assign in_ready = rst_n & (~stg_valid_r | out_ready);
  assign accept   = in_valid & in_ready;

  assign empty_now = (wr_ptr_r == rd_ptr_r);
  assign full_now  = (ring_next(wr_ptr_r) == rd_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    ok         = 1'b0;
    take_ok    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ring_next(wr_ptr_r);
    ram_raddr  = ring_next(rd_ptr_r);
    unique case (in_req_type)
      crdq_pkg::REQ_CLEAR: begin
        wr_ptr_nxt = '0;
        rd_ptr_nxt = '0;
        ok         = 1'b1;
      end
      crdq_pkg::REQ_APPEND: begin
        if (!full_now) begin
          wr_ptr_nxt = ring_next(wr_ptr_r);
          ram_we     = 1'b1;
          ok         = 1'b1;
        end
      end
      crdq_pkg::REQ_DELETE: begin
        if (!empty_now) begin
          wr_ptr_nxt = ring_prev(wr_ptr_r);
          ok         = 1'b1;
        end
      end
      crdq_pkg::REQ_TAKE: begin
        if (!empty_now) begin
          rd_ptr_nxt = ring_next(rd_ptr_r);
          take_ok    = 1'b1;
          ok         = 1'b1;
        end
      end
      crdq_pkg::REQ_UNGET: begin
        if (!full_now) begin
          // byte goes into the free slot, which then moves back one
          ram_waddr  = rd_ptr_r;
          rd_ptr_nxt = ring_prev(rd_ptr_r);
          ram_we     = 1'b1;
          ok         = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // read only on a taken byte so the RAM output holds while the result stalls
  assign ram_re = accept & take_ok;

  crdq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (accept & ram_we),
    .waddr(ram_waddr),
    .wdata(in_char_in),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_nxt       = stg_r;
    if (stg_valid_r && out_ready) begin
      stg_valid_nxt = 1'b0;
    end
    if (accept) begin
      stg_valid_nxt    = 1'b1;
      stg_nxt.take_ok  = take_ok;
      stg_nxt.ok       = ok;
      stg_nxt.is_empty = (wr_ptr_nxt == rd_ptr_nxt);
      stg_nxt.is_full  = (ring_next(wr_ptr_nxt) == rd_ptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      stg_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
      end
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign out_valid    = stg_valid_r;
  assign out_char_out = stg_r.take_ok ? ram_rdata : 8'd0;
  assign out_ok       = stg_r.ok;
  assign out_is_empty = stg_r.is_empty;
  assign out_is_full  = stg_r.is_full;

  // empty and full can never both be reported
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full reported together");

  // a take on an empty buffer is refused and stays empty
  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == crdq_pkg::REQ_TAKE && empty_now)
      |=> (out_valid && !out_ok && out_is_empty && out_char_out == 8'd0))
    else $error("take on empty buffer not refused");

  // clear always succeeds and leaves the buffer empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == crdq_pkg::REQ_CLEAR)
      |=> (out_valid && out_ok && out_is_empty))
    else $error("clear did not empty the buffer");

  // a stalled result keeps its pointers' view: no item slips past it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(wr_ptr_r) && $stable(rd_ptr_r)))
    else $error("state moved while result stalled");

endmodule
